[hw/rtl/pnid_pkg.sv]
package pnid_pkg;

	localparam int unsigned POS_W      = 10;
	localparam int unsigned PAL_DEPTH  = 15;
	localparam int unsigned PAL_AW     = 4;
	localparam int unsigned RGB_W      = 24;

	localparam logic [POS_W-1:0] POS_MAX   = 10'd1023;
	localparam logic [POS_W-1:0] HDR_LEN   = 10'd4;
	localparam logic [POS_W-1:0] BLOB_LEN  = 10'd565;
	localparam logic [POS_W-1:0] PAL_START = 10'd5;
	localparam logic [POS_W-1:0] PAL_FIRST = 10'd8;
	localparam logic [POS_W-1:0] PIX_START = 10'd53;
	localparam logic [POS_W-1:0] PIX_BYTES = 10'd512;
	localparam logic [7:0]       ALPHA     = 8'hff;
	localparam logic [7:0]       FMT_MASK  = 8'h80;

	// Reciprocal of three scaled by 128, exact for palette offsets below 48.
	localparam logic [11:0] RECIP3 = 12'd43;

	localparam logic [7:0] MAGIC [4] = '{8'h45, 8'h4d, 8'h42, 8'h44};

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BAD_LEN  = 3'd2,
		ST_BAD_FMT  = 3'd3,
		ST_REJECTED = 3'd4
	} status_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [2:0]        lane;
		logic [7:0]        data;
	} pal_wr_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr_hi;
		logic [PAL_AW-1:0] addr_lo;
	} pal_rd_t;

	// Everything one accepted byte hands to the result sequencer.
	typedef struct packed {
		logic             load;
		logic             has_pix;
		logic             zero_hi;
		logic             zero_lo;
		logic [POS_W-1:0] base;
		logic             has_status;
		status_t          code;
	} item_t;

endpackage

[hw/rtl/pnid_palette_ram.sv]
module pnid_palette_ram (
	input  logic                         clk,
	input  pnid_pkg::pal_wr_t            wr,
	input  pnid_pkg::pal_rd_t            rd,
	output logic [pnid_pkg::RGB_W-1:0]   rd_data_hi,
	output logic [pnid_pkg::RGB_W-1:0]   rd_data_lo
);

	logic [pnid_pkg::RGB_W-1:0] mem [pnid_pkg::PAL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.lane[0]) mem[wr.addr][23:16] <= wr.data;
			if (wr.lane[1]) mem[wr.addr][15:8] <= wr.data;
			if (wr.lane[2]) mem[wr.addr][7:0] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_hi <= mem[rd.addr_hi];
			rd_data_lo <= mem[rd.addr_lo];
		end
	end

endmodule

[hw/rtl/pnid_parser.sv]
module pnid_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 fire,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_stream,
	output pnid_pkg::pal_wr_t    pal_wr,
	output pnid_pkg::pal_rd_t    pal_rd,
	output pnid_pkg::item_t      item
);

	localparam int unsigned PW = pnid_pkg::POS_W;

	logic          hdr_en_q;
	logic [PW-1:0] pos_q;
	logic          all_zero_q;
	logic          fmt_err_q;
	logic          reply_nz_q;

	logic [PW-1:0] hlen;
	logic          in_hdr;
	logic [PW-1:0] q;
	logic          nz;
	logic          reply_nz_d;
	logic          all_zero_d;
	logic          fmt_err_d;
	logic [PW-1:0] pos_inc;
	logic          in_pal;
	logic          in_pix;
	logic [5:0]    pidx;
	logic [11:0]   prod;
	logic [3:0]    entry;
	logic [1:0]    lane;
	logic [PW-1:0] pq;
	logic [3:0]    nib_hi;
	logic [3:0]    nib_lo;
	logic          pix_ok;
	pnid_pkg::status_t code;

	always_comb begin
		hlen   = hdr_en_q ? pnid_pkg::HDR_LEN : '0;
		in_hdr = pos_q < hlen;
		q      = pos_q - hlen;
		nz     = data_byte != 8'd0;

		reply_nz_d = reply_nz_q | (in_hdr & nz);
		all_zero_d = all_zero_q & ~(~in_hdr & nz);
		fmt_err_d  = fmt_err_q;
		if (!in_hdr) begin
			if (q < pnid_pkg::HDR_LEN) begin
				if (data_byte != pnid_pkg::MAGIC[q[1:0]]) fmt_err_d = 1'b1;
			end else if (q == pnid_pkg::HDR_LEN) begin
				if ((data_byte & pnid_pkg::FMT_MASK) == 8'd0) fmt_err_d = 1'b1;
			end
		end

		pos_inc = (pos_q == pnid_pkg::POS_MAX) ? pos_q : pos_q + 10'd1;

		in_pal = !in_hdr && q >= pnid_pkg::PAL_FIRST && q < pnid_pkg::PIX_START;
		in_pix = !in_hdr && q >= pnid_pkg::PIX_START
			&& q < pnid_pkg::PIX_START + pnid_pkg::PIX_BYTES;

		// Entry and color lane of a palette byte, divided by three through the reciprocal.
		pidx  = 6'(q - pnid_pkg::PAL_START);
		prod  = 12'(pidx) * pnid_pkg::RECIP3;
		entry = prod[10:7];
		lane  = 2'(pidx - 6'(entry) * 6'd3);

		pal_wr.en   = fire & in_pal;
		pal_wr.addr = entry - 4'd1;
		pal_wr.lane = 3'b001 << lane;
		pal_wr.data = data_byte;

		nib_hi = data_byte[7:4];
		nib_lo = data_byte[3:0];
		pix_ok = in_pix & ~fmt_err_q & ~reply_nz_q;

		pal_rd.en      = fire & pix_ok;
		pal_rd.addr_hi = (nib_hi == 4'd0) ? 4'd0 : nib_hi - 4'd1;
		pal_rd.addr_lo = (nib_lo == 4'd0) ? 4'd0 : nib_lo - 4'd1;

		pq = q - pnid_pkg::PIX_START;

		if (hdr_en_q && pos_inc < pnid_pkg::HDR_LEN) code = pnid_pkg::ST_BAD_LEN;
		else if (reply_nz_d) code = pnid_pkg::ST_REJECTED;
		else if (pos_inc != pnid_pkg::BLOB_LEN + hlen) code = pnid_pkg::ST_BAD_LEN;
		else if (all_zero_d) code = pnid_pkg::ST_EMPTY;
		else if (fmt_err_d) code = pnid_pkg::ST_BAD_FMT;
		else code = pnid_pkg::ST_OK;

		item.has_pix    = pix_ok;
		item.zero_hi    = nib_hi == 4'd0;
		item.zero_lo    = nib_lo == 4'd0;
		item.base       = {pq[PW-2:0], 1'b0};
		item.has_status = end_of_stream;
		item.code       = code;
		item.load       = fire & (pix_ok | end_of_stream);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_en_q   <= 1'b0;
			pos_q      <= '0;
			all_zero_q <= 1'b1;
			fmt_err_q  <= 1'b0;
			reply_nz_q <= 1'b0;
		end else begin
			if (cfg_wr_en) hdr_en_q <= cfg_wr_data;
			if (fire) begin
				if (end_of_stream) begin
					pos_q      <= '0;
					all_zero_q <= 1'b1;
					fmt_err_q  <= 1'b0;
					reply_nz_q <= 1'b0;
				end else begin
					pos_q      <= pos_inc;
					all_zero_q <= all_zero_d;
					fmt_err_q  <= fmt_err_d;
					reply_nz_q <= reply_nz_d;
				end
			end
		end
	end

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !end_of_stream && pos_q != pnid_pkg::POS_MAX |=> pos_q == $past(pos_q) + 10'd1)
		else $error("byte position did not advance");

	a_stream_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_stream |=> pos_q == '0 && all_zero_q && !fmt_err_q && !reply_nz_q)
		else $error("stream state not cleared at end of stream");

	// Palette bytes precede pixel bytes, so a write and a read never share a request.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pal_wr.en && pal_rd.en))
		else $error("palette write and read in the same request");

endmodule

[hw/rtl/pnid_result_seq.sv]
module pnid_result_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pnid_pkg::item_t              item,
	input  logic [pnid_pkg::RGB_W-1:0]   rd_data_hi,
	input  logic [pnid_pkg::RGB_W-1:0]   rd_data_lo,
	output logic                         free,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         is_status,
	output logic [31:0]                  pixel_bgra,
	output logic [9:0]                   pixel_index,
	output logic [2:0]                   status,
	output logic                         last_of_run
);

	logic                   valid_s1;
	logic                   has_pix_s1;
	logic                   zero_hi_s1;
	logic                   zero_lo_s1;
	logic [9:0]             base_s1;
	logic                   has_status_s1;
	pnid_pkg::status_t      code_s1;
	logic [1:0]             sub_q;

	logic                   pix_slot;
	logic                   take;

	always_comb begin
		pix_slot    = has_pix_s1 && sub_q != 2'd2;
		last_of_run = has_status_s1 ? !pix_slot : sub_q == 2'd1;
		out_valid   = valid_s1;
		take        = valid_s1 & out_ready;
		free        = !valid_s1 || (out_ready && last_of_run);

		is_status   = !pix_slot;
		pixel_bgra  = 32'd0;
		pixel_index = 10'd0;
		status      = 3'(pnid_pkg::ST_OK);
		if (pix_slot) begin
			pixel_index = base_s1 | 10'(sub_q[0]);
			if (sub_q[0] == 1'b0) begin
				pixel_bgra = zero_hi_s1 ? 32'd0 : {pnid_pkg::ALPHA, rd_data_hi};
			end else begin
				pixel_bgra = zero_lo_s1 ? 32'd0 : {pnid_pkg::ALPHA, rd_data_lo};
			end
		end else begin
			status = 3'(code_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sub_q    <= 2'd0;
		end else begin
			if (item.load) begin
				valid_s1 <= 1'b1;
				sub_q    <= item.has_pix ? 2'd0 : 2'd2;
			end else if (take) begin
				if (last_of_run) valid_s1 <= 1'b0;
				else sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.load) begin
			has_pix_s1    <= item.has_pix;
			zero_hi_s1    <= item.zero_hi;
			zero_lo_s1    <= item.zero_lo;
			base_s1       <= item.base;
			has_status_s1 <= item.has_status;
			code_s1       <= item.code;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		item.load |-> free)
		else $error("new request loaded over an undelivered result");

	a_mid_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_of_run |=> out_valid && sub_q == $past(sub_q) + 2'd1)
		else $error("result run broken before its last result");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sub_q == 2'd2 |-> has_status_s1)
		else $error("status slot without a status");

endmodule

[hw/rtl/palette_nibble_image_decoder_core.sv]
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------------------
// input     | in_valid / in_ready   | data_byte, end_of_stream
// output    | out_valid / out_ready | is_status, pixel_bgra, pixel_index, status,
//           |                       | last_of_run
// config    | cfg_wr_en             | cfg_wr_data (reply header present)
//
// One byte request is taken per cycle unless the output stalls; a pixel byte yields
// two results and the final byte adds a status; the next byte waits for the last result.
// Palette bytes are written into the palette RAM when taken; a pixel byte reads both
// nibble entries from its two read ports in the same cycle, and the RAM registers them.
// Reset clears the stream counters and flags at once; the palette needs no clearing.
// A stalled output holds the current result and blocks the next byte request.
module palette_nibble_image_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_status,
	output logic [31:0] pixel_bgra,
	output logic [9:0]  pixel_index,
	output logic [2:0]  status,
	output logic        last_of_run
);

	pnid_pkg::pal_wr_t           pal_wr;
	pnid_pkg::pal_rd_t           pal_rd;
	pnid_pkg::item_t             item;
	logic [pnid_pkg::RGB_W-1:0]  rd_data_hi;
	logic [pnid_pkg::RGB_W-1:0]  rd_data_lo;
	logic                        free;
	logic                        fire;

	assign in_ready = free;
	assign fire     = in_valid & free;

	pnid_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fire          (fire),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.pal_wr        (pal_wr),
		.pal_rd        (pal_rd),
		.item          (item)
	);

	pnid_palette_ram u_ram (
		.clk        (clk),
		.wr         (pal_wr),
		.rd         (pal_rd),
		.rd_data_hi (rd_data_hi),
		.rd_data_lo (rd_data_lo)
	);

	pnid_result_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.rd_data_hi  (rd_data_hi),
		.rd_data_lo  (rd_data_lo),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_status   (is_status),
		.pixel_bgra  (pixel_bgra),
		.pixel_index (pixel_index),
		.status      (status),
		.last_of_run (last_of_run)
	);

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> last_of_run && pixel_bgra == 32'd0)
		else $error("status result not last or carries a pixel");

endmodule

[bench/tb_palette_nibble_image_decoder_core.sv]
`timescale 1ns / 100ps

module tb_palette_nibble_image_decoder_core;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_AFTER     = 12;

	typedef enum int {K_GOOD, K_BADFMT, K_REJECT, K_NOISE, K_ZERO} stream_kind_t;

	typedef struct {
		logic              is_st;
		logic [31:0]       bgra;
		logic [9:0]        idx;
		pnid_pkg::status_t code;
		logic              last;
	} pix_res_t;

	typedef struct {
		bit                set_hdr;
		bit                hdr;
		logic [7:0]        b;
		bit                eos;
		bit                typed;
		pnid_pkg::status_t code;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_status;
	logic [31:0] pixel_bgra;
	logic [9:0]  pixel_index;
	logic [2:0]  status;
	logic        last_of_run;

	// Decoder state as seen from the outside.
	logic [pnid_pkg::POS_W-1:0] pos_cnt = '0;
	logic [pnid_pkg::RGB_W-1:0] pal [1:15];
	logic                       blob_zero = 1'b1;
	logic                       fmt_bad = 1'b0;
	logic                       reply_bad = 1'b0;
	logic                       hdr_on = 1'b0;

	pix_res_t decoded_q [$];

	bit                hdr_now = 1'b0;
	bit                row_typed = 1'b0;
	pnid_pkg::status_t row_code = pnid_pkg::ST_OK;
	bit                in_burst = 1'b0;
	bit                out_burst = 1'b0;
	bit                held = 1'b0;

	int fail_count = 0;
	int in_cnt = 0;
	int result_cnt = 0;
	int stream_cnt = 0;
	int st_seen [5] = '{0, 0, 0, 0, 0};
	int idle_cycles = 0;

	dir_row_t dir_tab [19] = '{
		'{0, 0, 8'h00,              1, 1, pnid_pkg::ST_BAD_LEN},
		'{0, 0, 8'hff,              1, 1, pnid_pkg::ST_BAD_LEN},
		'{0, 0, pnid_pkg::MAGIC[0], 0, 0, pnid_pkg::ST_OK},
		'{0, 0, pnid_pkg::MAGIC[1], 0, 0, pnid_pkg::ST_OK},
		'{0, 0, pnid_pkg::MAGIC[2], 0, 0, pnid_pkg::ST_OK},
		'{0, 0, pnid_pkg::MAGIC[3], 0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h80,              1, 1, pnid_pkg::ST_BAD_LEN},
		'{1, 1, 8'h00,              1, 1, pnid_pkg::ST_BAD_LEN},
		'{0, 0, 8'h00,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h00,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h00,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h00,              1, 1, pnid_pkg::ST_BAD_LEN},
		'{0, 0, 8'h00,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h00,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h01,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h00,              1, 1, pnid_pkg::ST_REJECTED},
		'{0, 0, 8'h80,              0, 0, pnid_pkg::ST_OK},
		'{0, 0, 8'h00,              1, 1, pnid_pkg::ST_BAD_LEN},
		'{1, 0, 8'h7f,              1, 1, pnid_pkg::ST_BAD_LEN}
	};

	palette_nibble_image_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_status(is_status),
		.pixel_bgra(pixel_bgra),
		.pixel_index(pixel_index),
		.status(status),
		.last_of_run(last_of_run)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] nib_color(input logic [3:0] n);
		if (n == 4'd0)
			return 32'h0;
		return {pnid_pkg::ALPHA, pal[n]};
	endfunction

	function automatic void push_result(input logic st, input logic [31:0] px,
			input logic [9:0] idx, input pnid_pkg::status_t code);
		pix_res_t r;
		r.is_st = st;
		r.bgra = px;
		r.idx = idx;
		r.code = code;
		r.last = 1'b0;
		decoded_q.push_back(r);
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic eos);
		int unsigned h, q, off, n, cnt;
		pnid_pkg::status_t code;
		h = hdr_on ? int'(pnid_pkg::HDR_LEN) : 0;
		n = 0;
		if (pos_cnt < h) begin
			if (b != 8'h00)
				reply_bad = 1'b1;
		end else begin
			q = pos_cnt - h;
			if (b != 8'h00)
				blob_zero = 1'b0;
			if (q < 4) begin
				if (b != pnid_pkg::MAGIC[q])
					fmt_bad = 1'b1;
			end else if (q == 4) begin
				if ((b & pnid_pkg::FMT_MASK) == 8'h00)
					fmt_bad = 1'b1;
			end else if (q >= pnid_pkg::PAL_FIRST && q < pnid_pkg::PIX_START) begin
				off = q - pnid_pkg::PAL_START;
				case (off % 3)
					0: pal[off / 3][23:16] = b;
					1: pal[off / 3][15:8] = b;
					default: pal[off / 3][7:0] = b;
				endcase
			end else if (q >= pnid_pkg::PIX_START
					&& q < pnid_pkg::PIX_START + pnid_pkg::PIX_BYTES) begin
				if (!fmt_bad && !reply_bad) begin
					push_result(1'b0, nib_color(b[7:4]),
						10'((q - pnid_pkg::PIX_START) * 2), pnid_pkg::ST_OK);
					push_result(1'b0, nib_color(b[3:0]),
						10'((q - pnid_pkg::PIX_START) * 2 + 1), pnid_pkg::ST_OK);
					n += 2;
				end
			end
		end
		if (pos_cnt != pnid_pkg::POS_MAX)
			pos_cnt = pos_cnt + 1'b1;
		if (eos) begin
			cnt = pos_cnt;
			if (h == pnid_pkg::HDR_LEN && cnt < pnid_pkg::HDR_LEN)
				code = pnid_pkg::ST_BAD_LEN;
			else if (reply_bad)
				code = pnid_pkg::ST_REJECTED;
			else if (cnt - h != pnid_pkg::BLOB_LEN)
				code = pnid_pkg::ST_BAD_LEN;
			else if (blob_zero)
				code = pnid_pkg::ST_EMPTY;
			else if (fmt_bad)
				code = pnid_pkg::ST_BAD_FMT;
			else
				code = pnid_pkg::ST_OK;
			push_result(1'b1, 32'h0, 10'd0, code);
			n++;
			pos_cnt = '0;
			blob_zero = 1'b1;
			fmt_bad = 1'b0;
			reply_bad = 1'b0;
			for (int e = 1; e <= 15; e++)
				pal[e] = '0;
		end
		if (n > 0)
			decoded_q[decoded_q.size() - 1].last = 1'b1;
	endtask

	// Configuration, byte requests and results are all sampled here, in that order.
	always @(posedge clk) begin : monitor
		pix_res_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				hdr_on = cfg_wr_data;
			if (in_valid && in_ready) begin
				in_cnt++;
				if (end_of_stream)
					stream_cnt++;
				decode_byte(data_byte, end_of_stream);
				if (row_typed && end_of_stream)
					decoded_q[decoded_q.size() - 1].code = row_code;
			end
			if (out_valid && out_ready) begin
				result_cnt++;
				if (is_status && status < 5)
					st_seen[status]++;
				if (decoded_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected result: st=%0d px=%h idx=%0d code=%0d last=%0d",
							$realtime, is_status, pixel_bgra, pixel_index, status,
							last_of_run);
				end else begin
					want = decoded_q.pop_front();
					if (is_status !== want.is_st || pixel_bgra !== want.bgra ||
							pixel_index !== want.idx || status !== want.code ||
							last_of_run !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t mismatch: want st=%0d px=%h idx=%0d code=%0d last=%0d",
								$realtime, want.is_st, want.bgra, want.idx, want.code,
								want.last);
							$display("%0t           got  st=%0d px=%h idx=%0d code=%0d last=%0d",
								$realtime, is_status, pixel_bgra, pixel_index, status,
								last_of_run);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: random stalls per result, plus one long hold so the input backs up.
	initial begin : drain
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && result_cnt >= HOLD_AFTER) begin
				held = 1'b1;
				w = LONG_HOLD;
			end else begin
				w = out_burst ? 0 : $urandom_range(0, 7);
			end
			if ($urandom_range(0, 29) == 0)
				out_burst = !out_burst;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
			input pnid_pkg::status_t code);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 29) == 0)
			in_burst = !in_burst;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		row_typed = typed;
		row_code = code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_hdr(input bit v);
		idle_input();
		while (decoded_q.size() != 0)
			@(negedge clk);
		// Bytes that give no result may still be in flight.
		repeat (8) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		hdr_now = v;
	endtask

	task automatic send_stream(input stream_kind_t kind, input int blob_len);
		int hl, total, q, bad_at, rej_at;
		logic [7:0] b, rej_val;
		hl = hdr_now ? 4 : 0;
		total = hl + blob_len;
		bad_at = $urandom_range(0, 4);
		rej_at = $urandom_range(0, 3);
		rej_val = 8'($urandom_range(1, 255));
		for (int i = 0; i < total; i++) begin
			q = i - hl;
			if (kind == K_NOISE)
				b = 8'($urandom_range(0, 255));
			else if (kind == K_ZERO)
				b = 8'h00;
			else if (i < hl)
				b = (kind == K_REJECT && i == rej_at) ? rej_val : 8'h00;
			else if (q < 4)
				b = (kind == K_BADFMT && q == bad_at) ?
					pnid_pkg::MAGIC[q] ^ (8'h01 << $urandom_range(0, 7)) :
					pnid_pkg::MAGIC[q];
			else if (q == 4)
				b = (kind == K_BADFMT && bad_at == 4) ?
					(8'($urandom_range(0, 255)) & ~pnid_pkg::FMT_MASK) :
					(8'($urandom_range(0, 255)) | pnid_pkg::FMT_MASK);
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b, i == total - 1, 1'b0, pnid_pkg::ST_OK);
		end
	endtask

	initial begin : stim
		stream_kind_t kind;
		int len, pick;
		for (int e = 1; e <= 15; e++)
			pal[e] = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[r]) begin
			if (dir_tab[r].set_hdr)
				write_hdr(dir_tab[r].hdr);
			send_byte(dir_tab[r].b, dir_tab[r].eos, dir_tab[r].typed, dir_tab[r].code);
		end

		for (int ph = 0; ph < 2; ph++) begin
			write_hdr(ph == 1);
			// Each phase carries one stream long enough to reach the pixel bytes.
			send_stream(K_GOOD, $urandom_range(60, 68));
			for (int s = 0; s < 3; s++) begin
				pick = $urandom_range(0, 9);
				if (pick < 5)
					kind = K_GOOD;
				else if (pick == 5 || pick == 6)
					kind = K_BADFMT;
				else if (pick == 7)
					kind = K_REJECT;
				else if (pick == 8)
					kind = K_NOISE;
				else
					kind = K_ZERO;
				len = $urandom_range(1, 8);
				send_stream(kind, len);
			end
		end

		idle_input();
		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("run: %0d streams, %0d byte requests, %0d results, %0d mismatches",
			stream_cnt, in_cnt, result_cnt, fail_count);
		$display("status results: ok %0d, empty %0d, bad length %0d, bad format %0d, rejected %0d",
			st_seen[pnid_pkg::ST_OK], st_seen[pnid_pkg::ST_EMPTY],
			st_seen[pnid_pkg::ST_BAD_LEN], st_seen[pnid_pkg::ST_BAD_FMT],
			st_seen[pnid_pkg::ST_REJECTED]);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/pnid_pkg.sv
hw/rtl/pnid_palette_ram.sv
hw/rtl/pnid_parser.sv
hw/rtl/pnid_result_seq.sv
hw/rtl/palette_nibble_image_decoder_core.sv
bench/tb_palette_nibble_image_decoder_core.sv
